// ===== rtl/core/mce_pkg.sv =====
`timescale 1ns / 1ps

package mce_pkg;

  localparam int unsigned TIME_BITS_DEF = 12;
  localparam int unsigned IVAL_W        = 12;
  localparam int unsigned CHAR_W        = 8;
  localparam int unsigned CFG_ADDR_W    = 3;
  localparam int unsigned STEP_W        = 3;
  localparam int unsigned PAT_W         = 4;
  localparam int unsigned CNT_W         = 3;
  localparam int unsigned IN_DATA_W     = 8;
  localparam int unsigned OUT_DATA_W    = 16;

  localparam logic [31:0] RST_DOT   = 32'd50;
  localparam logic [31:0] RST_DASH  = 32'd150;
  localparam logic [31:0] RST_EGAP  = 32'd50;
  localparam logic [31:0] RST_LGAP  = 32'd150;
  localparam logic [31:0] RST_WGAP  = 32'd350;

  localparam logic [CFG_ADDR_W-1:0] REG_DOT  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DASH = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_EGAP = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_LGAP = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_WGAP = 3'd4;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  localparam logic [STEP_W-1:0] STEP_DECODE = 3'd0;
  localparam logic [STEP_W-1:0] STEP_ELEM   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_GAP    = 3'd2;
  localparam logic [STEP_W-1:0] STEP_LGAP   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_WORD   = 3'd4;

  typedef enum logic [1:0] {
    SRC_SYM  = 2'd0,
    SRC_EGAP = 2'd1,
    SRC_LGAP = 2'd2,
    SRC_WGAP = 2'd3
  } src_t;

  typedef enum logic [1:0] {
    COND_NEXT     = 2'd0,
    COND_ALWAYS   = 2'd1,
    COND_LOOP     = 2'd2,
    COND_DISPATCH = 2'd3
  } cond_t;

  typedef struct packed {
    logic              accept;
    logic              emit;
    logic              tone;
    logic              last;
    logic              shift;
    src_t              src;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic in_space;
    logic in_letter;
    logic cnt_last;
    logic out_free;
  } stat_t;

  // Element patterns, first element in the top bit, dash = 1
  localparam logic [PAT_W-1:0] SYM_PAT [26] = '{
    4'd4,  4'd8,  4'd10, 4'd8,  4'd0,  4'd2,  4'd12, 4'd0,  4'd0,  4'd7,
    4'd10, 4'd4,  4'd12, 4'd8,  4'd14, 4'd6,  4'd13, 4'd4,  4'd0,  4'd8,
    4'd2,  4'd1,  4'd6,  4'd9,  4'd11, 4'd12
  };

  localparam logic [CNT_W-1:0] SYM_LEN [26] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
    3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
    3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };

  function automatic ctrl_t mce_rom(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '{accept: 1'b0, emit: 1'b0, tone: 1'b0, last: 1'b0, shift: 1'b0,
          src: SRC_SYM, cond: COND_ALWAYS, target: STEP_DECODE};
    case (step)
      STEP_DECODE: begin
        w.accept = 1'b1;
        w.cond   = COND_DISPATCH;
        w.target = STEP_WORD;
      end
      STEP_ELEM: begin
        w.emit = 1'b1;
        w.tone = 1'b1;
        w.src  = SRC_SYM;
        w.cond = COND_NEXT;
      end
      STEP_GAP: begin
        w.emit   = 1'b1;
        w.shift  = 1'b1;
        w.src    = SRC_EGAP;
        w.cond   = COND_LOOP;
        w.target = STEP_ELEM;
      end
      STEP_LGAP: begin
        w.emit   = 1'b1;
        w.last   = 1'b1;
        w.src    = SRC_LGAP;
        w.cond   = COND_ALWAYS;
        w.target = STEP_DECODE;
      end
      STEP_WORD: begin
        w.emit   = 1'b1;
        w.last   = 1'b1;
        w.src    = SRC_WGAP;
        w.cond   = COND_ALWAYS;
        w.target = STEP_DECODE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_DECODE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/mce_seq.sv =====
`timescale 1ns / 1ps

module mce_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  input  mce_pkg::stat_t stat,
  output mce_pkg::ctrl_t ctrl
);

  logic [mce_pkg::STEP_W-1:0] step_r;
  logic [mce_pkg::STEP_W-1:0] step_nxt;
  logic [mce_pkg::STEP_W-1:0] step_inc;
  logic                       advance;

  assign ctrl     = mce_pkg::mce_rom(step_r);
  assign step_inc = mce_pkg::STEP_W'(step_r + 1'b1);

  always_comb begin
    if (ctrl.accept) begin
      advance = in_tvalid;
    end else if (ctrl.emit) begin
      advance = stat.out_free;
    end else begin
      advance = 1'b1;
    end
  end

  always_comb begin
    step_nxt = step_r;
    if (advance) begin
      case (ctrl.cond)
        mce_pkg::COND_NEXT:   step_nxt = step_inc;
        mce_pkg::COND_ALWAYS: step_nxt = ctrl.target;
        mce_pkg::COND_LOOP:   step_nxt = stat.cnt_last ? step_inc : ctrl.target;
        mce_pkg::COND_DISPATCH: begin
          if (stat.in_space) begin
            step_nxt = ctrl.target;
          end else if (stat.in_letter) begin
            step_nxt = step_inc;
          end else begin
            step_nxt = step_r;
          end
        end
        default: step_nxt = mce_pkg::STEP_DECODE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= mce_pkg::STEP_DECODE;
    end else begin
      step_r <= step_nxt;
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= mce_pkg::STEP_WORD)
    else $error("step counter outside program");

  a_space_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.accept && in_tvalid && stat.in_space |=> step_r == mce_pkg::STEP_WORD)
    else $error("space request not sent to word gap");

  a_other_drop: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.accept && in_tvalid && !stat.in_space && !stat.in_letter
    |=> step_r == mce_pkg::STEP_DECODE)
    else $error("ignored request left decode step");

endmodule

// ===== rtl/core/mce_dp.sv =====
`timescale 1ns / 1ps

module mce_dp #(
  parameter int unsigned TIME_BITS = mce_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [mce_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [TIME_BITS-1:0]           cfg_wdata,
  input  logic                           in_tvalid,
  input  logic [mce_pkg::CHAR_W-1:0]     char_code,
  input  mce_pkg::ctrl_t                 ctrl,
  output mce_pkg::stat_t                 stat,
  input  logic                           out_tready,
  output logic                           out_tvalid,
  output logic                           out_tone,
  output logic [mce_pkg::IVAL_W-1:0]     out_time,
  output logic                           out_tlast
);

  logic [TIME_BITS-1:0] dot_r, dash_r, egap_r, lgap_r, wgap_r;
  logic [TIME_BITS-1:0] sel_time;
  logic [mce_pkg::IVAL_W+TIME_BITS-1:0] sel_ext;

  logic [mce_pkg::PAT_W-1:0] pat_r, pat_nxt;
  logic [mce_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [4:0]                letter_idx;
  logic                      is_letter;
  logic                      load;
  logic                      fire;

  logic                      out_valid_r, out_valid_nxt;
  logic                      out_tone_r;
  logic [mce_pkg::IVAL_W-1:0] out_time_r;
  logic                      out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r  <= TIME_BITS'(mce_pkg::RST_DOT);
      dash_r <= TIME_BITS'(mce_pkg::RST_DASH);
      egap_r <= TIME_BITS'(mce_pkg::RST_EGAP);
      lgap_r <= TIME_BITS'(mce_pkg::RST_LGAP);
      wgap_r <= TIME_BITS'(mce_pkg::RST_WGAP);
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        mce_pkg::REG_DOT:  dot_r  <= cfg_wdata;
        mce_pkg::REG_DASH: dash_r <= cfg_wdata;
        mce_pkg::REG_EGAP: egap_r <= cfg_wdata;
        mce_pkg::REG_LGAP: lgap_r <= cfg_wdata;
        mce_pkg::REG_WGAP: wgap_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // fold case: both letter ranges share the low five bits
  assign is_letter  = (char_code[7:6] == 2'b01) && (char_code[4:0] != 5'd0) &&
                      (char_code[4:0] <= 5'd26);
  assign letter_idx = 5'(char_code[4:0] - 5'd1);

  assign stat.in_space  = (char_code == mce_pkg::CHAR_SPACE);
  assign stat.in_letter = is_letter;
  assign stat.cnt_last  = (cnt_r == mce_pkg::CNT_W'(1));
  assign stat.out_free  = !out_valid_r || out_tready;

  assign load = ctrl.accept && in_tvalid && is_letter;
  assign fire = ctrl.emit && stat.out_free;

  always_comb begin
    pat_nxt = pat_r;
    cnt_nxt = cnt_r;
    if (load) begin
      pat_nxt = mce_pkg::SYM_PAT[letter_idx];
      cnt_nxt = mce_pkg::SYM_LEN[letter_idx];
    end else if (fire && ctrl.shift) begin
      pat_nxt = {pat_r[mce_pkg::PAT_W-2:0], 1'b0};
      cnt_nxt = mce_pkg::CNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pat_r <= pat_nxt;
  end

  always_comb begin
    case (ctrl.src)
      mce_pkg::SRC_SYM:  sel_time = pat_r[mce_pkg::PAT_W-1] ? dash_r : dot_r;
      mce_pkg::SRC_EGAP: sel_time = egap_r;
      mce_pkg::SRC_LGAP: sel_time = lgap_r;
      mce_pkg::SRC_WGAP: sel_time = wgap_r;
      default:           sel_time = egap_r;
    endcase
  end

  assign sel_ext = {{mce_pkg::IVAL_W{1'b0}}, sel_time};

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_tone_r <= ctrl.tone;
      out_time_r <= sel_ext[mce_pkg::IVAL_W-1:0];
      out_last_r <= ctrl.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tone   = out_tone_r;
  assign out_time   = out_time_r;
  assign out_tlast  = out_last_r;

  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit && (ctrl.src == mce_pkg::SRC_SYM || ctrl.src == mce_pkg::SRC_EGAP)
    |-> cnt_r != '0)
    else $error("element step with no elements left");

  a_tone_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tone_r |-> !out_last_r)
    else $error("tone interval marked as run end");

  a_load_len: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> cnt_r != '0 && cnt_r <= mce_pkg::CNT_W'(mce_pkg::PAT_W))
    else $error("bad element count after letter load");

endmodule

// ===== rtl/core/morse_char_encoder.sv =====
`timescale 1ns / 1ps

// International Morse letter encoder. Each input byte is one request: a
// letter (either case) yields a tone and a silence per dot or dash, then one
// letter-gap silence; a space yields one word-gap silence; any other byte
// yields nothing. Every result carries tone_on and interval_time in
// out_tdata, with out_tlast on the final interval of the request. The block
// reports durations only and does not time them. A sequencer steps through
// one control word per cycle while not held, waiting at its decode step
// for in_tvalid; each tone or silence step loads a single output register.
// While the output register holds a result that out_tready has not yet
// taken, the sequencer holds at its current tone or silence step. The five
// timing registers are written through cfg_wr_en/cfg_addr/cfg_wdata
// (0 dot, 1 dash, 2 element gap, 3 letter gap, 4 word gap; other indexes
// ignored) and should be changed only while the block is idle.

module morse_char_encoder #(
  parameter int unsigned TIME_BITS = mce_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [mce_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [TIME_BITS-1:0]           cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mce_pkg::IN_DATA_W-1:0]  in_tdata,   // [7:0] char_code
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [mce_pkg::OUT_DATA_W-1:0] out_tdata,  // [0] tone_on, [12:1] interval_time
  output logic                           out_tlast
);

  mce_pkg::ctrl_t             ctrl;
  mce_pkg::stat_t             stat;
  logic                       out_tone;
  logic [mce_pkg::IVAL_W-1:0] out_time;

  mce_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  mce_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .char_code  (in_tdata[mce_pkg::CHAR_W-1:0]),
    .ctrl       (ctrl),
    .stat       (stat),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tone   (out_tone),
    .out_time   (out_time),
    .out_tlast  (out_tlast)
  );

  assign in_tready = ctrl.accept;
  assign out_tdata = {{(mce_pkg::OUT_DATA_W - mce_pkg::IVAL_W - 1){1'b0}}, out_time, out_tone};

endmodule
